[hdl/mwd_pkg.sv]
// Shared types and constants for the motion window detector.
`default_nettype none
package mwd_pkg;
    localparam int PIX_W = 24;
    localparam int SUM_W = 26;
    localparam int POS_W = 10;
    localparam int THR_W = 18;
    localparam int PER_W = 8;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             found;
    } t_result;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction
endpackage
`default_nettype wire

[hdl/motion_window_detector.sv]
// Top level: pixel stream in, window scan, result out, APB registers.
// The next word is accepted only once the window adds of the current pixel have been
// issued: d is formed in the cycle after acceptance, then each window that contains
// the pixel (0 to 4 of them) gets one read-modify-write of the window-sum memory per
// cycle. A pixel that lies in no window (past the last centre plus half a window)
// gets no read-modify-write. After reset a clearing pass zeroes all
// FRAME_ROWS*FRAME_COLS entries of the frame store (and the sums) before the first
// pixel. After the pixel that ends a scan period, the scan reads the sums one per
// cycle, clearing each, then emits a word; it waits while the previous result word
// has not been taken.
`default_nettype none
module motion_window_detector #(
    parameter int FRAME_ROWS = 240,
    parameter int FRAME_COLS = 320,
    parameter int WIN_ROWS   = 16,
    parameter int WIN_COLS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red, green, blue
    input  wire logic        s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // centre_row, centre_col, best_sum, motion_found, pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int GR = (FRAME_ROWS + WIN_ROWS - 1) / WIN_ROWS;
    localparam int GC = (FRAME_COLS + WIN_COLS - 1) / WIN_COLS;
    localparam int NW = GR * GC;
    localparam int NP = FRAME_ROWS * FRAME_COLS;
    localparam int PA_W = $clog2(NP);
    localparam int WA_W = $clog2(NW + 1);
    localparam int HR = WIN_ROWS / 2;
    localparam int HC = WIN_COLS / 2;
    localparam int AREA = WIN_ROWS * WIN_COLS;
    localparam int GR_W = $clog2(GR + 1);
    localparam int GC_W = $clog2(GC + 1);
    localparam int SW = mwd_pkg::SUM_W;
    // reciprocals for grid index division: exact for positions below 2^11
    localparam int DIV_SH = 21;
    localparam int RCP_R = ((1 << DIV_SH) + WIN_ROWS - 1) / WIN_ROWS;
    localparam int RCP_C = ((1 << DIV_SH) + WIN_COLS - 1) / WIN_COLS;

    // config
    logic [7:0]  r_period;
    logic [17:0] r_thresh;
    logic        wr;
    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 8'd4;
            r_thresh <= '0;
        end else if (wr) begin
            if (paddr[2:2] == 1'(mwd_pkg::REG_PERIOD)) r_period <= pwdata[7:0];
            else r_thresh <= pwdata[17:0];
        end
    end
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_period} : {14'd0, r_thresh};

    mwd_pkg::t_state r_st;
    logic [PA_W:0]  r_clr;
    logic [9:0]     r_row, r_col;
    logic [7:0]     r_fcnt;
    logic           r_dv;
    logic [9:0]     r_pr, r_pc;
    logic           r_last;
    // window add sequencer (one pixel pending)
    logic           r_busy;
    logic [GR_W-1:0] r_k1, r_k;
    logic [GC_W-1:0] r_m0, r_m1, r_m;
    logic [9:0]     r_d;
    logic           r_scan_req;

    logic accept, pix_en;
    logic [PA_W-1:0] paddr_pix;
    logic [9:0] diff;
    assign s_axis_tready = (r_st == mwd_pkg::ST_RUN) && !r_dv && !r_busy && !r_scan_req;
    assign accept = s_axis_tvalid & s_axis_tready;
    assign paddr_pix = (r_st == mwd_pkg::ST_CLEAR) ? r_clr[PA_W-1:0]
                     : PA_W'(32'(r_row) * FRAME_COLS + 32'(r_col));
    assign pix_en = accept || (r_st == mwd_pkg::ST_CLEAR);

    mwd_frame_mem #(.DEPTH(NP), .ADDR_W(PA_W)) u_fm (
        .i_clk(i_clk), .i_en(pix_en), .i_addr(paddr_pix), .i_pix(s_axis_tdata),
        .i_clr(r_st == mwd_pkg::ST_CLEAR), .o_diff(diff));

    // window sum memory: read one, write one per cycle
    logic [SW-1:0] r_ws [NW];
    logic [SW-1:0] r_rd;
    logic [WA_W-1:0] rd_a, r_wa;
    logic          r_wv;
    logic [SW-1:0] wdat;
    logic          r_rmw;      // read issued last cycle for add
    logic [9:0]    r_rd_d;
    logic [WA_W-1:0] r_rd_a;
    logic [WA_W-1:0] r_sidx;
    logic          r_srv;
    logic [SW-1:0] r_best;
    logic [9:0]    r_kr, r_kc;
    logic [GR_W-1:0] r_sk;
    logic [GC_W-1:0] r_sm;
    logic [GR_W-1:0] r_bk;
    logic [GC_W-1:0] r_bm;
    logic [GR_W-1:0] r_rsk;
    logic [GC_W-1:0] r_rsm;
    mwd_pkg::t_result r_res;
    logic          r_ov;

    function automatic logic [10:0] div_win(input logic [10:0] x, input logic [31:0] rcp);
        logic [31:0] p;
        p = 32'(x) * rcp;
        div_win = p[DIV_SH+10:DIV_SH];
    endfunction
    function automatic logic [10:0] first_w(input logic [10:0] p, input int st, input int h,
                                            input logic [31:0] rcp);
        logic [10:0] q;
        q = p - 11'(h) + 11'(st - 1);
        if (p <= 11'(h)) first_w = '0;
        else first_w = div_win(q, rcp);
    endfunction
    function automatic logic [10:0] last_w(input logic [10:0] p, input int h,
                                           input int g, input logic [31:0] rcp);
        logic [10:0] v;
        v = div_win(p + 11'(h), rcp);
        last_w = (32'(v) >= g) ? 11'(g - 1) : v;
    endfunction

    // window index ranges of the pending pixel; empty past the last centre plus half a window
    logic [10:0] fk, lk, fm, lm;
    assign fk = first_w({1'b0, r_pr}, WIN_ROWS, HR, 32'(RCP_R));
    assign lk = last_w({1'b0, r_pr}, HR, GR, 32'(RCP_R));
    assign fm = first_w({1'b0, r_pc}, WIN_COLS, HC, 32'(RCP_C));
    assign lm = last_w({1'b0, r_pc}, HC, GC, 32'(RCP_C));

    logic issue;
    logic [SW-1:0] cur;
    logic [SW:0] sumw;
    assign issue = r_busy;
    assign rd_a = (r_st == mwd_pkg::ST_SCAN) ? r_sidx
                : WA_W'(32'(r_k) * GC + 32'(r_m));
    // forward the in-flight write
    assign cur = (r_wv && r_wa == r_rd_a) ? wdat : r_rd;
    assign sumw = {1'b0, cur} + (SW+1)'(r_rd_d);
    logic [SW-1:0] addv;
    assign addv = sumw[SW] ? mwd_pkg::SUM_MAX : sumw[SW-1:0];

    logic [SW-1:0] r_wd;
    assign wdat = r_wd;

    always_ff @(posedge i_clk) begin
        r_rd <= r_ws[rd_a];
        if (r_wv) r_ws[r_wa] <= r_wd;
    end

    logic [SW+17:0] limit;
    assign limit = (SW+18)'(r_thresh) * (SW+18)'(AREA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mwd_pkg::ST_CLEAR;
            r_clr <= '0; r_row <= '0; r_col <= '0; r_fcnt <= '0;
            r_dv <= 1'b0; r_busy <= 1'b0; r_rmw <= 1'b0; r_wv <= 1'b0;
            r_scan_req <= 1'b0; r_srv <= 1'b0; r_ov <= 1'b0;
            r_kr <= '0; r_kc <= 10'(WIN_COLS); r_sidx <= '0;
        end else begin
            r_wv <= 1'b0;
            r_rmw <= 1'b0;
            r_srv <= 1'b0;
            case (r_st)
                mwd_pkg::ST_CLEAR: begin
                    r_wv <= (32'(r_clr) < NW);
                    r_wa <= WA_W'(r_clr);
                    r_wd <= '0;
                    if (32'(r_clr) == NP - 1) r_st <= mwd_pkg::ST_RUN;
                    r_clr <= r_clr + 1'b1;
                end
                mwd_pkg::ST_RUN: begin
                    r_dv <= accept;
                    if (accept) begin
                        r_pr <= r_row; r_pc <= r_col; r_last <= s_axis_tlast;
                        if (s_axis_tlast) begin
                            r_row <= '0; r_col <= '0;
                        end else if (32'(r_col) == FRAME_COLS - 1) begin
                            r_col <= '0;
                            r_row <= (32'(r_row) == FRAME_ROWS - 1) ? '0 : r_row + 1'b1;
                        end else r_col <= r_col + 1'b1;
                    end
                    if (r_dv) begin
                        r_d <= diff;
                        // skip the adds when the pixel lies in no window
                        r_busy <= (fk <= lk) && (fm <= lm);
                        r_k <= GR_W'(fk);
                        r_k1 <= GR_W'(lk);
                        r_m0 <= GC_W'(fm);
                        r_m <= GC_W'(fm);
                        r_m1 <= GC_W'(lm);
                        if (r_last) begin
                            if (32'(r_fcnt) + 1 >= ((r_period == 8'd0) ? 1 : 32'(r_period))) begin
                                r_fcnt <= '0;
                                r_scan_req <= 1'b1;
                            end else r_fcnt <= r_fcnt + 1'b1;
                        end
                    end
                    if (issue) begin
                        r_rmw <= 1'b1; r_rd_a <= rd_a; r_rd_d <= r_d;
                        if (r_m == r_m1) begin
                            r_m <= r_m0;
                            if (r_k == r_k1) r_busy <= 1'b0;
                            else r_k <= r_k + 1'b1;
                        end else r_m <= r_m + 1'b1;
                    end
                    if (r_rmw) begin
                        r_wv <= 1'b1; r_wa <= r_rd_a; r_wd <= addv;
                    end
                    if (r_scan_req && !r_busy && !r_rmw && !r_dv) begin
                        r_scan_req <= 1'b0;
                        r_st <= mwd_pkg::ST_SCAN;
                        r_sidx <= '0; r_sk <= '0; r_sm <= '0;
                        r_best <= '0; r_bk <= '0; r_bm <= '0;
                    end
                end
                mwd_pkg::ST_SCAN: begin
                    if (32'(r_sidx) < NW) begin
                        r_srv <= 1'b1; r_rd_a <= r_sidx;
                        r_rsk <= r_sk; r_rsm <= r_sm;
                        r_sidx <= r_sidx + 1'b1;
                        r_wv <= 1'b1; r_wa <= r_sidx; r_wd <= '0;
                        if (32'(r_sm) == GC - 1) begin
                            r_sm <= '0; r_sk <= r_sk + 1'b1;
                        end else r_sm <= r_sm + 1'b1;
                    end
                    if (r_srv && r_rd > r_best) begin
                        r_best <= r_rd; r_bk <= r_rsk; r_bm <= r_rsm;
                    end
                    if (32'(r_sidx) == NW && !r_srv) r_st <= mwd_pkg::ST_OUT;
                end
                mwd_pkg::ST_OUT: begin
                    if (!r_ov) begin
                        logic [9:0] kr, kc;
                        kr = (r_best != '0) ? 10'(32'(r_bk) * WIN_ROWS) : r_kr;
                        kc = (r_best != '0) ? 10'(32'(r_bm) * WIN_COLS) : r_kc;
                        r_kr <= kr; r_kc <= kc;
                        r_res.row <= kr; r_res.col <= kc; r_res.sum <= r_best;
                        r_res.found <= ((SW+18)'(r_best) > limit);
                        r_ov <= 1'b1;
                        r_st <= mwd_pkg::ST_RUN;
                    end
                end
                default: r_st <= mwd_pkg::ST_CLEAR;
            endcase
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {1'b0, r_res.found, r_res.sum, r_res.col, r_res.row};
endmodule
`default_nettype wire

[hdl/mwd_frame_mem.sv]
// Previous-frame pixel store with difference computation.
`default_nettype none
module mwd_frame_mem #(
    parameter int DEPTH  = 76800,
    parameter int ADDR_W = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [23:0]       i_pix,
    input  wire logic              i_clr,
    output logic [9:0]             o_diff
);
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_old;
    logic [23:0] r_new;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_old <= r_mem[i_addr];
            r_mem[i_addr] <= i_clr ? 24'd0 : i_pix;
        end
        r_new <= i_pix;
    end

    assign o_diff = 10'(mwd_pkg::abs_diff(r_new[23:16], r_old[23:16]))
                  + 10'(mwd_pkg::abs_diff(r_new[15:8], r_old[15:8]))
                  + 10'(mwd_pkg::abs_diff(r_new[7:0], r_old[7:0]));
endmodule
`default_nettype wire

[tb/sv/mwd_checker.sv]
// Checker for the motion window detector: predicts scan results and compares them.
`timescale 1ns / 1ps
module mwd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_pix_valid,
    input  wire logic        i_pix_ready,
    input  wire logic [23:0] i_pix_data,   // red, green, blue
    input  wire logic        i_pix_last,   // frame_end
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [47:0] i_res_data,   // centre_row, centre_col, best_sum, motion_found, pad
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);
    localparam int ROWS = 240;
    localparam int COLS = 320;
    localparam int WR = 16;
    localparam int WC = 16;
    localparam int GR = (ROWS + WR - 1) / WR;
    localparam int GC = (COLS + WC - 1) / WC;
    localparam int SUM_W = mwd_pkg::SUM_W;
    localparam int POS_W = mwd_pkg::POS_W;
    localparam int PER_W = mwd_pkg::PER_W;
    localparam int THR_W = mwd_pkg::THR_W;
    localparam logic [SUM_W-1:0] SUM_MAX = mwd_pkg::SUM_MAX;

    logic [23:0]      prev_pix [ROWS*COLS];
    logic [SUM_W-1:0] win_sum [GR*GC];
    int               cur_row, cur_col, frames_seen;
    logic [POS_W-1:0] hold_row, hold_col;
    logic [PER_W-1:0] period_reg;
    logic [THR_W-1:0] thresh_reg;
    mwd_pkg::t_result scan_q[$];

    function automatic int udiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic absorb_pixel(input logic [23:0] pix, input logic last);
        int r, c, addr, d, k, m, k0, m0, per;
        longint t;
        logic [23:0] old;
        mwd_pkg::t_result res;
        logic [SUM_W-1:0] best;
        r = (cur_row >= ROWS) ? 0 : cur_row;
        c = (cur_col >= COLS) ? 0 : cur_col;
        addr = r * COLS + c;
        old = prev_pix[addr];
        d = udiff(pix[7:0], old[7:0]) + udiff(pix[15:8], old[15:8])
            + udiff(pix[23:16], old[23:16]);
        k0 = (r <= WR/2) ? 0 : (r - WR/2 + WR - 1) / WR;
        m0 = (c <= WC/2) ? 0 : (c - WC/2 + WC - 1) / WC;
        for (k = k0; k < GR && k * WR <= r + WR/2; k++)
            for (m = m0; m < GC && m * WC <= c + WC/2; m++) begin
                t = longint'(win_sum[k*GC+m]) + d;
                win_sum[k*GC+m] = (t > longint'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
            end
        prev_pix[addr] = pix;
        if (!last) begin
            c++;
            if (c >= COLS) begin
                c = 0;
                r++;
                if (r >= ROWS) r = 0;
            end
            cur_row = r;
            cur_col = c;
            return;
        end
        cur_row = 0;
        cur_col = 0;
        per = (period_reg == 0) ? 1 : period_reg;
        frames_seen = (frames_seen + 1) & 8'hFF;
        if (frames_seen < per) return;
        frames_seen = 0;
        best = '0;
        for (k = 0; k < GR; k++)
            for (m = 0; m < GC; m++)
                if (win_sum[k*GC+m] > best) begin
                    best = win_sum[k*GC+m];
                    hold_row = POS_W'(k * WR);
                    hold_col = POS_W'(m * WC);
                end
        foreach (win_sum[i]) win_sum[i] = '0;
        res.row = hold_row;
        res.col = hold_col;
        res.sum = best;
        res.found = (longint'(best) > longint'(thresh_reg) * WR * WC);
        scan_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        mwd_pkg::t_result got, want;
        if (!i_rst_n) begin
            foreach (prev_pix[i]) prev_pix[i] = '0;
            foreach (win_sum[i]) win_sum[i] = '0;
            cur_row = 0;
            cur_col = 0;
            frames_seen = 0;
            hold_row = '0;
            hold_col = POS_W'(WC);
            period_reg = 8'd4;
            thresh_reg = '0;
            scan_q.delete();
            o_fail_count = 0;
            o_results_seen = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2:2] == 1'(mwd_pkg::REG_PERIOD)) period_reg = i_pwdata[PER_W-1:0];
                else thresh_reg = i_pwdata[THR_W-1:0];
            end
            if (i_pix_valid && i_pix_ready) absorb_pixel(i_pix_data, i_pix_last);
            if (i_res_valid && i_res_ready) begin
                got.row = i_res_data[9:0];
                got.col = i_res_data[19:10];
                got.sum = i_res_data[45:20];
                got.found = i_res_data[46];
                o_results_seen++;
                if (scan_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word row=%0d col=%0d sum=%0d found=%0b",
                                 got.row, got.col, got.sum, got.found);
                end else begin
                    want = scan_q.pop_front();
                    if (got.row !== want.row || got.col !== want.col
                        || got.sum !== want.sum || got.found !== want.found) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp row=%0d col=%0d sum=%0d found=%0b, %s%0d %0d %0d %0b",
                                     want.row, want.col, want.sum, want.found,
                                     "got ", got.row, got.col, got.sum, got.found);
                    end
                end
            end
        end
        o_pending = scan_q.size();
    end
endmodule

[tb/sv/tb_motion_window_detector.sv]
// Testbench top: pixel stimulus, register writes, idling phases and verdict.
`timescale 1ns / 1ps
module tb_motion_window_detector;
    localparam int IDLE_LIMIT = 400000;
    localparam int SETTLE = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, results_seen;
    int          idle_pct = 0, stall_pct = 0;
    int          pixels_sent = 0, idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    motion_window_detector DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tlast(s_last),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mwd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pix_valid(s_valid), .i_pix_ready(s_ready), .i_pix_data(s_data),
        .i_pix_last(s_last),
        .i_res_valid(m_valid), .i_res_ready(m_ready), .i_res_data(m_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always @(posedge i_clk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    // Stop if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [23:0] pix, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= pix;
        s_last <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx[0], 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(4))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        int len;
        logic [23:0] flat;
        case ($urandom_range(19))
            0: len = $urandom_range(700, 300);
            1, 2, 3, 4: len = $urandom_range(40, 9);
            default: len = $urandom_range(8, 1);
        endcase
        flat = rand_pixel();
        for (int i = 0; i < len; i++) begin
            // About one pixel in four repeats the frame's flat colour.
            if ($urandom_range(3) == 0) send_pixel(flat, i == len - 1);
            else send_pixel(rand_pixel(), i == len - 1 && $urandom_range(9) != 0);
        end
    endtask

    initial begin
        int phase_items;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no motion first, then extreme pixels and patterns.
        reg_write(mwd_pkg::REG_PERIOD, 1);
        reg_write(mwd_pkg::REG_THRESH, 0);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hAA55AA, 1'b0);
        send_pixel(24'h55AA55, 1'b0);
        send_pixel(24'hFF00FF, 1'b1);
        reg_write(mwd_pkg::REG_PERIOD, 0);
        send_pixel(24'h00FF00, 1'b1);
        send_pixel(24'h00FF00, 1'b1);
        reg_write(mwd_pkg::REG_THRESH, 262143);
        for (int i = 0; i < 12; i++) send_pixel(24'hFFFFFF ^ {24{i[0]}}, i == 11);
        reg_write(mwd_pkg::REG_THRESH, 1);
        for (int i = 0; i < 3; i++) send_pixel(24'h123456 << i, 1'b1);

        // Random phases over the idling modes and register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            reg_write(mwd_pkg::REG_PERIOD, (ph == 3) ? 0 : $urandom_range(3, 1));
            reg_write(mwd_pkg::REG_THRESH, (ph == 5) ? 262143 : $urandom_range(8));
            phase_items = pixels_sent + 120;
            while (pixels_sent < phase_items) random_frame();
        end

        // Longest period: 255 one-pixel frames per scan.
        idle_pct = 0;
        stall_pct = 0;
        reg_write(mwd_pkg::REG_PERIOD, 255);
        reg_write(mwd_pkg::REG_THRESH, 0);
        for (int i = 0; i < 255; i++) send_pixel(24'($urandom), 1'b1);

        reg_write(mwd_pkg::REG_PERIOD, 2);
        phase_items = pixels_sent + 250;
        while (pixels_sent < phase_items) random_frame();

        drain();
        $display("sent %0d pixels over four idling modes, checked %0d scan results",
                 pixels_sent, results_seen);
        $display("periods 0..255 and thresholds 0..262143 were exercised");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[filelist.f]
hdl/mwd_pkg.sv
hdl/mwd_frame_mem.sv
hdl/motion_window_detector.sv
tb/sv/mwd_checker.sv
tb/sv/tb_motion_window_detector.sv
